### design/dtmf_pkg.sv
// dtmf_pkg: shared types, register codes, frequency tables and the Q15 sine table
// for the dtmf digit tone generator; no dependencies
`default_nettype none

package dtmf_pkg;

	// item and result payloads
	typedef struct packed {
		logic       action;
		logic [3:0] digit_code;
		logic [3:0] length_multiplier;
	} item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               tone_on;
		logic               idle;
		logic               digit_accepted;
		logic               clipped;
	} result_t;

	// configuration channel
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LEVEL = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_LEVEL = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_MS  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS  = 8'd3;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_DIGIT = 1'b1;

	// duration bookkeeping: the count is kept as (ticks + 1) * 1000 against ms * rate
	localparam int                 CNT_W    = 27;
	localparam logic [CNT_W-1:0]   CNT_STEP = 27'd1000;
	localparam logic [CNT_W-1:0]   CNT_CAP  = 27'd131071999;
	localparam logic [9:0]         MS_MAX   = 10'd1000;

	// digit to tone pair
	localparam int DIGIT_CODES = 16;
	typedef logic [10:0] freq_tab_t [DIGIT_CODES];

	localparam freq_tab_t ROW_FREQ = '{
		11'd941, 11'd697, 11'd697, 11'd697, 11'd770, 11'd770, 11'd770, 11'd852,
		11'd852, 11'd852, 11'd941, 11'd941, 11'd697, 11'd770, 11'd852, 11'd941
	};
	localparam freq_tab_t COL_FREQ = '{
		11'd1336, 11'd1209, 11'd1336, 11'd1477, 11'd1209, 11'd1336, 11'd1477, 11'd1209,
		11'd1336, 11'd1477, 11'd1209, 11'd1477, 11'd1633, 11'd1633, 11'd1633, 11'd1633
	};

	// sine table geometry
	localparam int SINE_ENTRIES = 256;
	localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
	localparam int SINE_QUARTER = SINE_ENTRIES / 4;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

	// sin(pi/2 * r / quarter) in Q15 by a taylor series in Q30
	function automatic logic [15:0] quarter_sine(input logic [63:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		x  = (HALF_PI_Q30 * r) / SINE_QUARTER;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		return v[15:0];
	endfunction

	// full-wave table from the quarter wave
	function automatic sine_tab_t build_sine_rom();
		sine_tab_t   tab;
		int          quad;
		int          r;
		logic [15:0] v;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			quad = (i / SINE_QUARTER) % 4;
			r    = i % SINE_QUARTER;
			if (quad == 1 || quad == 3) begin
				v = quarter_sine(64'(SINE_QUARTER - r));
			end else begin
				v = quarter_sine(64'(r));
			end
			tab[i] = (quad >= 2) ? 16'(-v) : v;
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### design/dtmf_if.sv
// dtmf_if: valid/ready channels for digit/tick items, result items and register writes
// depends on dtmf_pkg
`default_nettype none

interface dtmf_item_if;
	logic                valid;
	logic                ready;
	dtmf_pkg::item_t     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dtmf_result_if;
	logic                valid;
	logic                ready;
	dtmf_pkg::result_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dtmf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dtmf_pkg::CFG_IDX_W-1:0]      index;
	logic [dtmf_pkg::CFG_DATA_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### design/dtmf_mix.sv
// dtmf_mix: two sine table lookups, level scaling, sum, scale by 2^-15 and saturation
// depends on dtmf_pkg
`default_nettype none

module dtmf_mix (
	input  wire logic [dtmf_pkg::SINE_IDX_W-1:0] row_idx,
	input  wire logic [dtmf_pkg::SINE_IDX_W-1:0] col_idx,
	input  wire logic [14:0]                     row_level,
	input  wire logic [14:0]                     col_level,
	output logic signed [15:0]                   sample,
	output logic                                 clipped
);
	import dtmf_pkg::*;

	logic signed [15:0] row_sine;
	logic signed [15:0] col_sine;
	logic signed [31:0] row_prod;
	logic signed [31:0] col_prod;
	logic signed [32:0] sum;
	logic signed [32:0] biased;
	logic signed [17:0] quot;

	// table lookups
	assign row_sine = SINE_ROM[row_idx];
	assign col_sine = SINE_ROM[col_idx];

	// level scaling, levels are unsigned
	assign row_prod = $signed({1'b0, row_level}) * row_sine;
	assign col_prod = $signed({1'b0, col_level}) * col_sine;

	// divide by 32768 toward zero
	assign sum    = 33'(row_prod) + 33'(col_prod);
	assign biased = sum + (sum[32] ? 33'sd32767 : 33'sd0);
	assign quot   = 18'(biased >>> 15);

	// saturate to 16 bits
	always_comb begin
		clipped = 1'b0;
		sample  = quot[15:0];
		if (quot > 18'sd32767) begin
			clipped = 1'b1;
			sample  = 16'sh7fff;
		end else if (quot < -18'sd32768) begin
			clipped = 1'b1;
			sample  = 16'sh8000;
		end
	end

endmodule

`default_nettype wire

### design/dtmf_digit_tone_generator.sv
// dtmf_digit_tone_generator: digit sequencing, phase accumulators, ramp-out and registers
// depends on dtmf_pkg, dtmf_if and dtmf_mix
// an item passes the input register, then the result register, where its result waits to
// be taken; throughput one item per cycle while results are taken, set by the combinational
// state update of the phase accumulators and duration count. the result register frees when
// taken, so a new item enters while a result waits. reset empties both registers, resets the
// tone state and loads the register defaults (levels 8000, 100 ms tone, 100 ms pause).
`default_nettype none

module dtmf_digit_tone_generator #(
	parameter int SAMPLE_RATE    = 8000,
	parameter int PHASE_BITS     = 16,
	parameter int MAX_MULTIPLIER = 15
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	dtmf_item_if.sink           items,
	dtmf_result_if.source       results,
	dtmf_cfg_if.sink            cfg
);
	import dtmf_pkg::*;

	// ms * rate widths
	localparam int DSR_W = $clog2(1000 * SAMPLE_RATE + 1);
	localparam int PW    = DSR_W + 4;
	localparam int LW    = (PW > CNT_W) ? PW : CNT_W;

	typedef logic [PHASE_BITS-1:0] step_tab_t [DIGIT_CODES];

	// phase increments, round(freq * 2^PHASE_BITS / rate)
	function automatic step_tab_t build_steps(input logic use_col);
		step_tab_t   tab;
		logic [63:0] f;
		logic [63:0] t;
		for (int i = 0; i < DIGIT_CODES; i++) begin
			f      = use_col ? 64'(COL_FREQ[i]) : 64'(ROW_FREQ[i]);
			t      = ((f << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
			tab[i] = t[PHASE_BITS-1:0];
		end
		return tab;
	endfunction

	localparam step_tab_t ROW_STEP = build_steps(1'b0);
	localparam step_tab_t COL_STEP = build_steps(1'b1);

	// handshake and pipeline registers
	logic    s1_valid_q;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	logic    advance;
	logic    fire;
	logic    in_ready;

	// configuration registers
	logic [14:0]      row_level_q;
	logic [14:0]      col_level_q;
	logic [DSR_W-1:0] digit_sr_q;
	logic [DSR_W-1:0] pause_sr_q;
	logic [9:0]       cfg_digit_ms;
	logic [9:0]       cfg_pause_ms;

	// tone state
	logic [PHASE_BITS-1:0] row_phase_q;
	logic [PHASE_BITS-1:0] col_phase_q;
	logic [PHASE_BITS-1:0] row_step_q;
	logic [PHASE_BITS-1:0] col_step_q;
	logic                  sounding_q;
	logic [CNT_W-1:0]      limit_q;
	logic [CNT_W-1:0]      acc_q;
	logic signed [15:0]    ramp_q;

	// next state
	logic [PHASE_BITS-1:0] row_phase_n;
	logic [PHASE_BITS-1:0] col_phase_n;
	logic [PHASE_BITS-1:0] row_step_n;
	logic [PHASE_BITS-1:0] col_step_n;
	logic                  sounding_n;
	logic [CNT_W-1:0]      limit_n;
	logic [CNT_W-1:0]      acc_n;
	logic signed [15:0]    ramp_n;
	result_t               result_n;

	logic                  busy;
	logic                  idle_now;
	logic [3:0]            mult;
	logic [PW-1:0]         tone_prod;
	logic [CNT_W-1:0]      tone_limit;
	logic [CNT_W-1:0]      pause_limit;
	logic signed [15:0]    mix_sample;
	logic                  mix_clipped;
	logic signed [15:0]    ramp_adj;
	logic signed [15:0]    ramp_half;

	// item flow: input register, then result register
	assign advance       = !out_valid_q || results.ready;
	assign fire          = s1_valid_q && advance;
	assign in_ready      = !s1_valid_q || advance;
	assign items.ready   = in_ready;
	assign results.valid = out_valid_q;
	assign results.data  = result_q;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && in_ready) begin
			item_s1 <= items.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_n;
		end
	end

	// register writes, durations stored as ms * rate
	always_comb begin
		cfg_digit_ms = cfg.wdata[9:0];
		if (cfg_digit_ms == 10'd0) begin
			cfg_digit_ms = 10'd1;
		end else if (cfg_digit_ms > MS_MAX) begin
			cfg_digit_ms = MS_MAX;
		end
		cfg_pause_ms = (cfg.wdata[9:0] > MS_MAX) ? MS_MAX : cfg.wdata[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_level_q <= 15'd8000;
			col_level_q <= 15'd8000;
			digit_sr_q  <= DSR_W'(100 * SAMPLE_RATE);
			pause_sr_q  <= DSR_W'(100 * SAMPLE_RATE);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROW_LEVEL: row_level_q <= cfg.wdata[14:0];
				REG_COL_LEVEL: col_level_q <= cfg.wdata[14:0];
				REG_DIGIT_MS: begin
					digit_sr_q <= DSR_W'(DSR_W'(cfg_digit_ms) * DSR_W'(SAMPLE_RATE));
				end
				REG_PAUSE_MS: begin
					pause_sr_q <= DSR_W'(DSR_W'(cfg_pause_ms) * DSR_W'(SAMPLE_RATE));
				end
				default: ;
			endcase
		end
	end

	// sample synthesis from the current phases
	dtmf_mix u_mix (
		.row_idx   (row_phase_q[PHASE_BITS-1 -: SINE_IDX_W]),
		.col_idx   (col_phase_q[PHASE_BITS-1 -: SINE_IDX_W]),
		.row_level (row_level_q),
		.col_level (col_level_q),
		.sample    (mix_sample),
		.clipped   (mix_clipped)
	);

	// samples left is nonzero while the running count has not passed the limit
	assign busy     = acc_q <= limit_q;
	assign idle_now = !sounding_q && !busy;

	// tone length: multiplier clamp, ms * rate * mult capped at the count limit
	always_comb begin
		mult = item_s1.length_multiplier;
		if (mult == 4'd0) begin
			mult = 4'd1;
		end
		if (32'(mult) > MAX_MULTIPLIER) begin
			mult = 4'(MAX_MULTIPLIER);
		end
	end

	assign tone_prod   = PW'(digit_sr_q) * PW'(mult);
	assign tone_limit  = (LW'(tone_prod) > LW'(CNT_CAP)) ? CNT_CAP : CNT_W'(tone_prod);
	assign pause_limit = CNT_W'(pause_sr_q);

	// ramp-out halves toward zero
	assign ramp_adj  = ramp_q + $signed({15'd0, ramp_q[15]});
	assign ramp_half = ramp_adj >>> 1;

	// per-item state update
	always_comb begin
		row_phase_n = row_phase_q;
		col_phase_n = col_phase_q;
		row_step_n  = row_step_q;
		col_step_n  = col_step_q;
		sounding_n  = sounding_q;
		limit_n     = limit_q;
		acc_n       = acc_q;
		ramp_n      = ramp_q;
		result_n    = '0;

		if (item_s1.action == ACT_DIGIT) begin
			// start a digit only when nothing is pending
			if (idle_now) begin
				row_step_n = ROW_STEP[item_s1.digit_code];
				col_step_n = COL_STEP[item_s1.digit_code];
				sounding_n = 1'b1;
				limit_n    = tone_limit;
				acc_n      = CNT_STEP;
				if (CNT_STEP > tone_limit) begin
					sounding_n = 1'b0;
					limit_n    = pause_limit;
				end
				result_n.digit_accepted = 1'b1;
			end
			result_n.tone_on = sounding_n;
		end else if (sounding_q) begin
			// tone tick
			result_n.sample  = mix_sample;
			result_n.clipped = mix_clipped;
			result_n.tone_on = 1'b1;
			ramp_n           = mix_sample;
			row_phase_n      = row_phase_q + row_step_q;
			col_phase_n      = col_phase_q + col_step_q;
			if (busy) begin
				acc_n = acc_q + CNT_STEP;
			end
			if (acc_n > limit_q) begin
				sounding_n = 1'b0;
				limit_n    = pause_limit;
				acc_n      = CNT_STEP;
			end
		end else begin
			// pause or idle tick: ramp-out, phases return to zero once it is done
			if (busy) begin
				acc_n = acc_q + CNT_STEP;
			end
			ramp_n          = ramp_half;
			result_n.sample = ramp_half;
			if (ramp_half == 16'sd0) begin
				row_phase_n = '0;
				col_phase_n = '0;
			end
		end

		result_n.idle = !sounding_n && (acc_n > limit_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_phase_q <= '0;
			col_phase_q <= '0;
			row_step_q  <= '0;
			col_step_q  <= '0;
			sounding_q  <= 1'b0;
			limit_q     <= '0;
			acc_q       <= CNT_STEP;
			ramp_q      <= '0;
		end else if (fire) begin
			row_phase_q <= row_phase_n;
			col_phase_q <= col_phase_n;
			row_step_q  <= row_step_n;
			col_step_q  <= col_step_n;
			sounding_q  <= sounding_n;
			limit_q     <= limit_n;
			acc_q       <= acc_n;
			ramp_q      <= ramp_n;
		end
	end

	// the running count never gets more than one step past its limit
	assert property (@(posedge clk) disable iff (!arst_n)
		LW'(acc_q) <= LW'(limit_q) + LW'(CNT_STEP))
		else $error("duration count ran past its limit");

	// an accepted digit yields a silent result with the tone on
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.digit_accepted |->
			result_q.sample == 16'sd0 && result_q.tone_on && !result_q.idle)
		else $error("accepted digit result malformed");

	// a clipped sample sits at full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.clipped |->
			result_q.sample == 16'sh7fff || result_q.sample == 16'sh8000)
		else $error("clipped sample not at full scale");

	// a stalled input register keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(item_s1))
		else $error("input register lost a stalled item");

	// a finished ramp-out leaves both phases at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.action == ACT_TICK && !sounding_q && ramp_q == 16'sd0 |=>
			row_phase_q == '0 && col_phase_q == '0)
		else $error("phases not cleared after ramp-out");

endmodule

`default_nettype wire
